// ----- hdl/acr_pkg.sv -----
// acr_pkg: shared types and constants for the atom contact row.
// Used by acr_cell, atom_contact_row, acr_row_checker and testbench; depends on nothing.

package acr_pkg;

   localparam int CUT_W  = 20;          // cutoff radius width
   localparam int SQ_W   = 2 * CUT_W;   // squared cutoff / squared axis distance
   localparam int SUM_W  = SQ_W + 2;    // sum of three squares
   localparam int MASK_W = 64;          // contact row width

   localparam logic [CUT_W-1:0] CUTOFF_RESET    = 20'd4000;
   localparam logic [SQ_W-1:0]  CUTOFF_SQ_RESET = 40'd16000000;

   typedef enum logic [1:0] {
      REQ_CLEAR = 2'd0,
      REQ_LOAD  = 2'd1,
      REQ_QUERY = 2'd2
   } req_code_type;

   // cutoff limits broadcast to every cell
   typedef struct packed {
      logic [CUT_W-1:0] cutoff;
      logic [SQ_W-1:0]  cutoff_sq;
   } limit_type;

endpackage

// ----- hdl/acr_cell.sv -----
// acr_cell: one cell of the contact row; holds one reference atom and tests
// the passing query atom against it. Depends on acr_pkg.

module acr_cell
   import acr_pkg::*;
#(
   parameter int COORD_WIDTH = 25
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          wr_en_i,
   input  logic signed [COORD_WIDTH-1:0] wr_x_i,
   input  logic signed [COORD_WIDTH-1:0] wr_y_i,
   input  logic signed [COORD_WIDTH-1:0] wr_z_i,
   input  limit_type                     lim_i,
   input  logic                          q_vld_i,
   input  logic signed [COORD_WIDTH-1:0] q_x_i,
   input  logic signed [COORD_WIDTH-1:0] q_y_i,
   input  logic signed [COORD_WIDTH-1:0] q_z_i,
   output logic                          q_vld_o,
   output logic signed [COORD_WIDTH-1:0] q_x_o,
   output logic signed [COORD_WIDTH-1:0] q_y_o,
   output logic signed [COORD_WIDTH-1:0] q_z_o,
   output logic                          hit_o
);

   // wide enough for a coordinate difference and for -cutoff
   localparam int EW = (COORD_WIDTH + 1 > CUT_W + 1) ? COORD_WIDTH + 1 : CUT_W + 1;

   logic signed [COORD_WIDTH-1:0] ref_x_ff, ref_y_ff, ref_z_ff;
   logic signed [COORD_WIDTH-1:0] q_x_ff, q_y_ff, q_z_ff;
   logic                          q_vld_ff;

   logic signed [EW-1:0] q_c   [3];
   logic signed [EW-1:0] ref_c [3];
   logic signed [EW-1:0] diff  [3];
   logic signed [EW-1:0] mag   [3];
   logic signed [EW-1:0] c_ext;
   logic [CUT_W-1:0]     s1_abs_in [3];
   logic                 s1_ok_in;

   logic                 s1_vld_ff, s1_ok_ff;
   logic [CUT_W-1:0]     s1_abs_ff [3];
   logic                 s2_vld_ff, s2_ok_ff;
   logic [SQ_W-1:0]      s2_sq_ff  [3];
   logic [SUM_W-1:0]     sum_in;
   logic                 hit_in;
   logic                 hit_ff;

   always_ff @(posedge clock) begin
      if (wr_en_i) begin
         ref_x_ff <= wr_x_i;
         ref_y_ff <= wr_y_i;
         ref_z_ff <= wr_z_i;
      end
   end

   // axis window test and magnitudes
   always_comb begin
      q_c[0]   = EW'(q_x_i);
      q_c[1]   = EW'(q_y_i);
      q_c[2]   = EW'(q_z_i);
      ref_c[0] = EW'(ref_x_ff);
      ref_c[1] = EW'(ref_y_ff);
      ref_c[2] = EW'(ref_z_ff);
      c_ext    = $signed({{(EW - CUT_W){1'b0}}, lim_i.cutoff});
      s1_ok_in = 1'b1;
      for (int a = 0; a < 3; a++) begin
         diff[a]      = q_c[a] - ref_c[a];
         mag[a]       = diff[a][EW-1] ? -diff[a] : diff[a];
         s1_abs_in[a] = mag[a][CUT_W-1:0];   // exact whenever the window holds
         if ((diff[a] > c_ext) || (diff[a] < -c_ext)) begin
            s1_ok_in = 1'b0;
         end
      end
   end

   always_comb begin
      sum_in = SUM_W'(s2_sq_ff[0]) + SUM_W'(s2_sq_ff[1]) + SUM_W'(s2_sq_ff[2]);
      hit_in = s2_ok_ff && (sum_in <= SUM_W'(lim_i.cutoff_sq));
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         q_vld_ff  <= 1'b0;
         s1_vld_ff <= 1'b0;
         s2_vld_ff <= 1'b0;
      end else begin
         q_vld_ff  <= q_vld_i;
         s1_vld_ff <= q_vld_i;
         s2_vld_ff <= s1_vld_ff;
      end
   end

   always_ff @(posedge clock) begin
      q_x_ff   <= q_x_i;
      q_y_ff   <= q_y_i;
      q_z_ff   <= q_z_i;
      s1_ok_ff <= s1_ok_in;
      s2_ok_ff <= s1_ok_ff;
      for (int a = 0; a < 3; a++) begin
         s1_abs_ff[a] <= s1_abs_in[a];
         s2_sq_ff[a]  <= SQ_W'(s1_abs_ff[a]) * SQ_W'(s1_abs_ff[a]);
      end
      if (s2_vld_ff) begin
         hit_ff <= hit_in;   // held until the next query's compare in this cell
      end
   end

   assign q_vld_o = q_vld_ff;
   assign q_x_o   = q_x_ff;
   assign q_y_o   = q_y_ff;
   assign q_z_o   = q_z_ff;
   assign hit_o   = hit_ff;

endmodule

// ----- hdl/atom_contact_row.sv -----
// atom_contact_row: top level of the contact row; count, cutoff register and
// the chain of acr_cell instances. Depends on acr_pkg and acr_cell.
//
//   channel   ports                                   handshake
//   request   req_type, req_coord_x/y/z               start & !busy
//   response  rsp_contact_mask                        rsp_valid strobe, one cycle
//   csr       csr_cutoff_distance                     csr_valid & csr_ready
//
// Clear and load beats never raise busy.
// A query walks the chain one cell per cycle; in each cell it passes the registered
// window, squares and compare stages, so its row appears after the last cell's compare,
// and busy drops in the same cycle as rsp_valid.
// Synchronous active-high reset empties the set and restores a 4000 cutoff.
// The receiver cannot stall: rsp_valid is a single-cycle strobe.

module atom_contact_row
   import acr_pkg::*;
#(
   parameter int STORE_DEPTH = 64,
   parameter int COORD_WIDTH = 25
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          start,
   output logic                          busy,
   input  logic [1:0]                    req_type,
   input  logic signed [COORD_WIDTH-1:0] req_coord_x,
   input  logic signed [COORD_WIDTH-1:0] req_coord_y,
   input  logic signed [COORD_WIDTH-1:0] req_coord_z,
   output logic                          rsp_valid,
   output logic [MASK_W-1:0]             rsp_contact_mask,
   input  logic                          csr_valid,
   output logic                          csr_ready,
   input  logic [CUT_W-1:0]              csr_cutoff_distance
);

   localparam int CNT_W = $clog2(STORE_DEPTH + 1);
   localparam int IDX_W = (STORE_DEPTH > 1) ? $clog2(STORE_DEPTH) : 1;

   logic                 busy_ff;
   logic [CNT_W-1:0]     count_ff;
   logic [CUT_W-1:0]     cutoff_ff;
   logic [SQ_W-1:0]      cutoff_sq_ff;
   logic                 tail1_ff, tail2_ff;
   logic                 rsp_valid_ff;
   logic [MASK_W-1:0]    mask_ff;
   logic [MASK_W-1:0]    mask_in;

   logic                 accept;
   logic                 load_ok;
   limit_type            lim;

   logic                          q_vld [0:STORE_DEPTH];
   logic signed [COORD_WIDTH-1:0] q_x   [0:STORE_DEPTH];
   logic signed [COORD_WIDTH-1:0] q_y   [0:STORE_DEPTH];
   logic signed [COORD_WIDTH-1:0] q_z   [0:STORE_DEPTH];
   logic [STORE_DEPTH-1:0]        hit;
   logic [STORE_DEPTH-1:0]        wr_en;

   assign accept  = start && !busy_ff;
   assign load_ok = accept && (req_type == REQ_LOAD) && (count_ff < CNT_W'(STORE_DEPTH));

   assign lim.cutoff    = cutoff_ff;
   assign lim.cutoff_sq = cutoff_sq_ff;

   assign q_vld[0] = accept && (req_type == REQ_QUERY);
   assign q_x[0]   = req_coord_x;
   assign q_y[0]   = req_coord_y;
   assign q_z[0]   = req_coord_z;

   genvar k;
   generate
      for (k = 0; k < STORE_DEPTH; k++) begin : g_cell
         assign wr_en[k] = load_ok && (count_ff[IDX_W-1:0] == IDX_W'(k));

         acr_cell #(
            .COORD_WIDTH(COORD_WIDTH)
         ) u_cell (
            .clock   (clock),
            .reset   (reset),
            .wr_en_i (wr_en[k]),
            .wr_x_i  (req_coord_x),
            .wr_y_i  (req_coord_y),
            .wr_z_i  (req_coord_z),
            .lim_i   (lim),
            .q_vld_i (q_vld[k]),
            .q_x_i   (q_x[k]),
            .q_y_i   (q_y[k]),
            .q_z_i   (q_z[k]),
            .q_vld_o (q_vld[k+1]),
            .q_x_o   (q_x[k+1]),
            .q_y_o   (q_y[k+1]),
            .q_z_o   (q_z[k+1]),
            .hit_o   (hit[k])
         );
      end
   endgenerate

   // only cells below the fill count contribute
   always_comb begin
      mask_in = '0;
      for (int i = 0; i < STORE_DEPTH; i++) begin
         mask_in[i] = hit[i] && (count_ff > CNT_W'(i));
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff      <= 1'b0;
         count_ff     <= '0;
         cutoff_ff    <= CUTOFF_RESET;
         cutoff_sq_ff <= CUTOFF_SQ_RESET;
         tail1_ff     <= 1'b0;
         tail2_ff     <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         cutoff_sq_ff <= SQ_W'(cutoff_ff) * SQ_W'(cutoff_ff);
         if (csr_valid) begin
            cutoff_ff <= csr_cutoff_distance;
         end
         if (accept && (req_type == REQ_CLEAR)) begin
            count_ff <= '0;
         end else if (load_ok) begin
            count_ff <= count_ff + CNT_W'(1);
         end
         // tail1 and tail2 track the query from the last cell to its compare
         tail1_ff     <= q_vld[STORE_DEPTH];
         tail2_ff     <= tail1_ff;
         rsp_valid_ff <= tail2_ff;
         if (q_vld[0]) begin
            busy_ff <= 1'b1;
         end else if (tail2_ff) begin
            busy_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (tail2_ff) begin
         mask_ff <= mask_in;
      end
   end

   assign busy             = busy_ff;
   assign rsp_valid        = rsp_valid_ff;
   assign rsp_contact_mask = mask_ff;
   assign csr_ready        = 1'b1;

`ifndef SYNTHESIS
   a_busy_ends_with_row: assert property (@(posedge clock) disable iff (reset)
      $fell(busy_ff) |-> rsp_valid_ff)
      else $error("busy dropped without a response beat");

   a_single_beat: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |=> !rsp_valid_ff)
      else $error("response strobe longer than one cycle");

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CNT_W'(STORE_DEPTH))
      else $error("fill count beyond store depth");

   a_row_above_count: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> ((mask_ff >> count_ff) == '0))
      else $error("contact bit set for an empty slot");
`endif

endmodule

// ----- verif/acr_row_checker.sv -----
`timescale 1ns / 100ps
// acr_row_checker: watches the request, response and csr channels of
// atom_contact_row, predicts every contact row and compares it. Depends on acr_pkg.

module acr_row_checker
   import acr_pkg::*;
#(
   parameter int STORE_DEPTH = 64,
   parameter int COORD_WIDTH = 25
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          start,
   input  logic                          busy,
   input  logic [1:0]                    req_type,
   input  logic signed [COORD_WIDTH-1:0] req_coord_x,
   input  logic signed [COORD_WIDTH-1:0] req_coord_y,
   input  logic signed [COORD_WIDTH-1:0] req_coord_z,
   input  logic                          rsp_valid,
   input  logic [MASK_W-1:0]             rsp_contact_mask,
   input  logic                          csr_valid,
   input  logic                          csr_ready,
   input  logic [CUT_W-1:0]              csr_cutoff_distance,
   output int                            pending_rows,
   output int                            fail_count
);

   typedef logic signed [COORD_WIDTH-1:0] coord_type;

   coord_type         atom_x [STORE_DEPTH];
   coord_type         atom_y [STORE_DEPTH];
   coord_type         atom_z [STORE_DEPTH];
   int                atom_count;
   logic [CUT_W-1:0]  cutoff;
   logic [MASK_W-1:0] rows_due [$];
   logic [MASK_W-1:0] row_want;

   // exact integer test: axis window first, then sum of squares
   function automatic logic [MASK_W-1:0] contact_row(coord_type qx, coord_type qy,
                                                     coord_type qz);
      logic [MASK_W-1:0] row;
      longint            lim;
      longint            dx;
      longint            dy;
      longint            dz;
      row = '0;
      lim = longint'(cutoff);
      for (int k = 0; k < atom_count; k++) begin
         dx = longint'(qx) - longint'(atom_x[k]);
         dy = longint'(qy) - longint'(atom_y[k]);
         dz = longint'(qz) - longint'(atom_z[k]);
         if (dx <= lim && dx >= -lim && dy <= lim && dy >= -lim &&
             dz <= lim && dz >= -lim) begin
            if (dx * dx + dy * dy + dz * dz <= lim * lim)
               row[k] = 1'b1;
         end
      end
      return row;
   endfunction

   task automatic report_mismatch(string what);
      if (fail_count < 40)
         $display("MISMATCH @%0t: %s", $time, what);
      fail_count++;
   endtask

   initial fail_count = 0;

   always @(posedge clock) begin
      if (reset) begin
         atom_count = 0;
         cutoff = CUTOFF_RESET;
         rows_due.delete();
      end else begin
         if (rsp_valid) begin
            if (rows_due.size() == 0) begin
               report_mismatch($sformatf("row %h with no query pending", rsp_contact_mask));
            end else begin
               row_want = rows_due.pop_front();
               if (rsp_contact_mask !== row_want)
                  report_mismatch($sformatf("contact_mask got %h want %h",
                                            rsp_contact_mask, row_want));
            end
         end
         if (csr_valid && csr_ready)
            cutoff = csr_cutoff_distance;
         if (start && !busy) begin
            case (req_type)
               REQ_CLEAR: atom_count = 0;
               REQ_LOAD: begin
                  // full store drops the atom
                  if (atom_count < STORE_DEPTH) begin
                     atom_x[atom_count] = req_coord_x;
                     atom_y[atom_count] = req_coord_y;
                     atom_z[atom_count] = req_coord_z;
                     atom_count++;
                  end
               end
               REQ_QUERY: rows_due.push_back(contact_row(req_coord_x, req_coord_y,
                                                         req_coord_z));
               default: ;
            endcase
         end
      end
      pending_rows <= rows_due.size();
   end

endmodule

// ----- verif/testbench.sv -----
`timescale 1ns / 100ps
// testbench: top of the atom_contact_row bench; clock, reset, request and cutoff
// stimulus, verdict. Depends on acr_pkg, atom_contact_row and acr_row_checker.

module testbench;
   import acr_pkg::*;

   localparam int         STORE_DEPTH   = 64;
   localparam int         COORD_WIDTH   = 25;
   localparam logic [1:0] REQ_SPARE     = 2'd3;   // unused code, block ignores it
   localparam int         SETTLE_CYCLES = STORE_DEPTH + 8;
   localparam int         MAX_GAP       = 16;
   localparam int         PHASE_ITEMS   = 330;

   typedef logic signed [COORD_WIDTH-1:0] coord_type;

   logic              clock = 1'b0;
   logic              reset;
   logic              start;
   logic              busy;
   logic [1:0]        req_type;
   coord_type         req_coord_x;
   coord_type         req_coord_y;
   coord_type         req_coord_z;
   logic              rsp_valid;
   logic [MASK_W-1:0] rsp_contact_mask;
   logic              csr_valid;
   logic              csr_ready;
   logic [CUT_W-1:0]  csr_cutoff_distance;
   int                pending_rows;
   int                fail_count;

   int idle_pct;
   int items_sent;
   int cur_cutoff;
   int pool_x [$];
   int pool_y [$];
   int pool_z [$];

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   atom_contact_row #(
      .STORE_DEPTH (STORE_DEPTH),
      .COORD_WIDTH (COORD_WIDTH)
   ) u_dut (.*);

   acr_row_checker #(
      .STORE_DEPTH (STORE_DEPTH),
      .COORD_WIDTH (COORD_WIDTH)
   ) u_checker (.*);

   function automatic int rand_off(int span);
      return int'($urandom_range(2 * span)) - span;
   endfunction

   // one request beat; start stays high into the next beat unless a gap is drawn
   task automatic issue(logic [1:0] kind, int x, int y, int z);
      int gap;
      gap = 0;
      while (gap < MAX_GAP && $urandom_range(99) < idle_pct)
         gap++;
      if (gap > 0) begin
         start <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      start       <= 1'b1;
      req_type    <= kind;
      req_coord_x <= coord_type'(x);
      req_coord_y <= coord_type'(y);
      req_coord_z <= coord_type'(z);
      @(posedge clock);
      while (busy) @(posedge clock);
      if (kind != REQ_SPARE)
         items_sent++;
      // pool of loaded atoms, only used to aim queries
      if (kind == REQ_CLEAR) begin
         pool_x.delete();
         pool_y.delete();
         pool_z.delete();
      end else if (kind == REQ_LOAD && pool_x.size() < STORE_DEPTH) begin
         pool_x.push_back(int'(coord_type'(x)));
         pool_y.push_back(int'(coord_type'(y)));
         pool_z.push_back(int'(coord_type'(z)));
      end
   endtask

   task automatic settle();
      start <= 1'b0;
      @(posedge clock);
      while (pending_rows != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_cutoff(int value);
      csr_valid           <= 1'b1;
      csr_cutoff_distance <= CUT_W'(value);
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      csr_valid  <= 1'b0;
      cur_cutoff = value;
   endtask

   task automatic aim_query();
      int span;
      int k;
      int tx;
      int ty;
      int tz;
      span = ($urandom_range(1) == 0) ? cur_cutoff / 2 + 1 : cur_cutoff + cur_cutoff / 4 + 1;
      if (pool_x.size() == 0) begin
         tx = rand_off(8000000);
         ty = rand_off(8000000);
         tz = rand_off(8000000);
      end else begin
         k  = $urandom_range(pool_x.size() - 1);
         tx = pool_x[k];
         ty = pool_y[k];
         tz = pool_z[k];
      end
      if ($urandom_range(7) == 0) begin
         // right on the axis window edge, or one past it
         issue(REQ_QUERY, tx + (cur_cutoff + int'($urandom_range(1))), ty, tz);
      end else begin
         issue(REQ_QUERY, tx + rand_off(span), ty + rand_off(span), tz + rand_off(span));
      end
   endtask

   task automatic run_phase(int budget, bit fill_first);
      int n_loads;
      int n_queries;
      int span;
      int cx;
      int cy;
      int cz;
      bit first;
      first = fill_first;
      while (items_sent < budget) begin
         if ($urandom_range(9) == 0) begin
            issue(2'($urandom_range(3)), $urandom, $urandom, $urandom);
         end else begin
            if (first || $urandom_range(3) != 0)
               issue(REQ_CLEAR, $urandom, $urandom, $urandom);
            n_loads = (first || $urandom_range(7) == 0) ? $urandom_range(72, 64)
                                                        : $urandom_range(12, 1);
            span = 2 * cur_cutoff + 50;
            cx = rand_off(8000000);
            cy = rand_off(8000000);
            cz = rand_off(8000000);
            for (int i = 0; i < n_loads; i++)
               issue(REQ_LOAD, cx + rand_off(span), cy + rand_off(span), cz + rand_off(span));
            n_queries = $urandom_range(8, 1);
            for (int i = 0; i < n_queries; i++)
               aim_query();
            first = 1'b0;
         end
      end
   endtask

   initial begin
      int phase_idle [6];
      phase_idle = '{0, 79, 20, 0, 79, 20};
      reset               = 1'b1;
      start               = 1'b0;
      req_type            = REQ_CLEAR;
      req_coord_x         = '0;
      req_coord_y         = '0;
      req_coord_z         = '0;
      csr_valid           = 1'b0;
      csr_cutoff_distance = CUTOFF_RESET;
      idle_pct            = 0;
      items_sent          = 0;
      cur_cutoff          = int'(CUTOFF_RESET);
      repeat (12) @(posedge clock);
      reset <= 1'b0;

      // directed beats at the reset cutoff
      issue(REQ_QUERY, 0, 0, 0);                       // empty set
      issue(REQ_SPARE, 123, -456, 789);
      issue(REQ_LOAD, 0, 0, 0);
      issue(REQ_LOAD, 9999999, -9999999, 9999999);
      issue(REQ_LOAD, -16777216, -16777216, -16777216);
      issue(REQ_LOAD, 16777215, 16777215, 16777215);
      issue(REQ_QUERY, 0, 0, 0);
      issue(REQ_QUERY, 4000, 0, 0);                    // on the sphere
      issue(REQ_QUERY, 0, -4001, 0);
      issue(REQ_QUERY, 2309, 2309, 2309);              // corner just inside
      issue(REQ_QUERY, -2310, 2310, -2310);            // corner just outside
      issue(REQ_QUERY, 9999999, -9999999, 9999999);
      issue(REQ_QUERY, -9999999, 9999999, -9999999);
      issue(REQ_QUERY, -16777216, -16777216, -16777216);
      issue(REQ_QUERY, 16777215, 16777215, 16777215);
      issue(REQ_SPARE, -1, -1, -1);
      issue(REQ_QUERY, 0, 0, 0);
      issue(REQ_CLEAR, -1, -1, -1);
      issue(REQ_QUERY, 0, 0, 0);
      settle();

      for (int p = 0; p < 6; p++) begin
         case (p)
            0:       write_cutoff(int'(CUTOFF_RESET));
            1:       write_cutoff(0);
            2:       write_cutoff((1 << CUT_W) - 1);
            3:       write_cutoff($urandom_range(20000, 1));
            4:       write_cutoff($urandom_range((1 << CUT_W) - 1));
            default: write_cutoff(1000);
         endcase
         idle_pct = phase_idle[p];
         run_phase(items_sent + PHASE_ITEMS, p == 0);
         settle();
      end

      if (fail_count == 0 && pending_rows == 0)
         $display("All tests passed");
      else
         $display("Some tests failed");
      $finish;
   end

   initial begin
      #10_000_000;
      $display("TIMEOUT at %0t", $time);
      $display("Some tests failed");
      $finish;
   end

endmodule

// ----- filelist.f -----
hdl/acr_pkg.sv
hdl/acr_cell.sv
hdl/atom_contact_row.sv
verif/acr_row_checker.sv
verif/testbench.sv
